>>> rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// shared types and constants of the open address hash table
// ----------------------------------------------------------------------------
package oaht_pkg;

	// table geometry, slot count must be a power of two
	localparam int SLOTS      = 256;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 64;
	localparam int FILL_W     = 9;
	localparam int LIMIT_W    = 8;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(192);

	typedef enum logic [1:0] {
		FN_GET   = 2'd0,
		FN_SET   = 2'd1,
		FN_DEL   = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_TOMB  = 2'd1,
		KIND_USED  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic {
		FSM_IDLE  = 1'b0,
		FSM_PROBE = 1'b1
	} fsm_t;

endpackage

>>> rtl/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/open_address_hash_table.sv
// ----------------------------------------------------------------------------
// open_address_hash_table
// key/value table, open addressing with linear probing and tombstones
//
// clear, a set refused by the fill limit, and get/delete on an empty table answer
//   in the cycle after the request is accepted
// otherwise the probe walks P slots (1 to SLOTS), one probe per cycle,
//   set by the single read port of the slot ram
// busy drops in the result cycle, so the next request is taken then
// reset: every slot reads empty through per-slot valid flags, fill count 0,
//   fill limit 192, no clearing pass; the receiver cannot stall results
// ----------------------------------------------------------------------------
module open_address_hash_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request channel
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             func,
	input  logic [oaht_pkg::KEY_BITS-1:0]          key_id,
	input  logic [31:0]                            key_hash,
	input  logic [oaht_pkg::VALUE_BITS-1:0]        value_in,
	// result channel
	output logic                                   done,
	output logic [1:0]                             status,
	output logic                                   new_key,
	output logic [oaht_pkg::VALUE_BITS-1:0]        value_out,
	// fill limit write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [oaht_pkg::LIMIT_W-1:0]           cfg_data
);

	// control state
	oaht_pkg::fsm_t                  state_q, state_d;
	logic [oaht_pkg::SLOTS-1:0]      valid_q;      // slot written since last clear
	logic [oaht_pkg::FILL_W-1:0]     fill_count_q;
	logic [oaht_pkg::LIMIT_W-1:0]    fill_limit_q;
	logic [oaht_pkg::IDX_W-1:0]      idx_q;        // slot whose data the ram returns
	logic [oaht_pkg::IDX_W-1:0]      probe_cnt_q;
	logic                            tomb_seen_q;
	logic [oaht_pkg::IDX_W-1:0]      tomb_idx_q;
	logic                            done_q;

	// request payload held during the probe
	oaht_pkg::func_t                 func_q;
	logic [oaht_pkg::KEY_BITS-1:0]   key_q;
	logic [oaht_pkg::VALUE_BITS-1:0] value_q;

	// result payload
	oaht_pkg::status_t               status_q;
	logic                            new_key_q;
	logic [oaht_pkg::VALUE_BITS-1:0] value_out_q;

	// slot ram
	logic                            ram_we;
	logic [oaht_pkg::IDX_W-1:0]      ram_wr_addr;
	oaht_pkg::slot_t                 ram_wr_data;
	logic                            ram_re;
	logic [oaht_pkg::IDX_W-1:0]      ram_rd_addr;
	oaht_pkg::slot_t                 ram_rd_data;
	logic [oaht_pkg::SLOT_W-1:0]     ram_rd_bits;

	// probe decode
	oaht_pkg::func_t                 func_in;
	logic                            accept;
	oaht_pkg::kind_t                 rd_kind;
	logic                            key_match;
	logic                            is_empty;
	logic                            is_tomb;
	logic                            last_probe;
	logic                            finish;
	logic                            tomb_any;
	logic [oaht_pkg::IDX_W-1:0]      tomb_first;
	logic [oaht_pkg::IDX_W-1:0]      sel_slot;
	logic                            sel_valid;
	logic                            sel_was_empty;
	logic                            over_limit;

	// result and state update requests
	logic                            res_fire;
	oaht_pkg::status_t               res_status;
	logic                            res_new;
	logic [oaht_pkg::VALUE_BITS-1:0] res_value;
	logic                            clear_all;
	logic                            fill_inc;
	logic                            probe_load;

	assign func_in   = oaht_pkg::func_t'(func);
	assign accept    = start && !busy;
	assign busy      = (state_q != oaht_pkg::FSM_IDLE);
	assign cfg_ready = 1'b1;

	assign done      = done_q;
	assign status    = status_q;
	assign new_key   = new_key_q;
	assign value_out = value_out_q;

	oaht_ram #(
		.WIDTH (oaht_pkg::SLOT_W),
		.DEPTH (oaht_pkg::SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_re),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_bits)
	);

	assign ram_rd_data = oaht_pkg::slot_t'(ram_rd_bits);

	// a slot never written since reset or clear reads as empty
	assign rd_kind    = valid_q[idx_q] ? ram_rd_data.kind : oaht_pkg::KIND_EMPTY;
	assign key_match  = (rd_kind == oaht_pkg::KIND_USED) && (ram_rd_data.key == key_q);
	assign is_empty   = (rd_kind == oaht_pkg::KIND_EMPTY);
	assign is_tomb    = (rd_kind == oaht_pkg::KIND_TOMB);
	assign last_probe = (probe_cnt_q == oaht_pkg::IDX_W'(oaht_pkg::SLOTS - 1));
	assign finish     = key_match || is_empty || last_probe;

	// first tombstone met wins over the empty slot that ends the chain
	assign tomb_any      = tomb_seen_q || is_tomb;
	assign tomb_first    = tomb_seen_q ? tomb_idx_q : idx_q;
	assign sel_slot      = key_match ? idx_q : (tomb_any ? tomb_first : idx_q);
	assign sel_valid     = key_match || is_empty || tomb_any;
	assign sel_was_empty = !key_match && !tomb_any && is_empty;

	// set is refused when one more slot would pass the limit
	assign over_limit = ((oaht_pkg::FILL_W+1)'(fill_count_q) + 1'b1)
		> (oaht_pkg::FILL_W+1)'(fill_limit_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oaht_pkg::FSM_IDLE: begin
				if (accept) begin
					case (func_in)
						oaht_pkg::FN_GET, oaht_pkg::FN_DEL: begin
							if (fill_count_q != '0) begin
								state_d = oaht_pkg::FSM_PROBE;
							end
						end
						oaht_pkg::FN_SET: begin
							if (!over_limit) begin
								state_d = oaht_pkg::FSM_PROBE;
							end
						end
						default: state_d = oaht_pkg::FSM_IDLE;
					endcase
				end
			end
			oaht_pkg::FSM_PROBE: begin
				if (finish) begin
					state_d = oaht_pkg::FSM_IDLE;
				end
			end
			default: state_d = oaht_pkg::FSM_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		res_fire    = 1'b0;
		res_status  = oaht_pkg::ST_DONE;
		res_new     = 1'b0;
		res_value   = '0;
		clear_all   = 1'b0;
		fill_inc    = 1'b0;
		probe_load  = 1'b0;
		ram_re      = 1'b0;
		ram_rd_addr = idx_q + 1'b1;
		ram_we      = 1'b0;
		ram_wr_addr = sel_slot;
		ram_wr_data = '{kind: oaht_pkg::KIND_USED, key: key_q, value: value_q};
		case (state_q)
			oaht_pkg::FSM_IDLE: begin
				// first probe slot is the hash modulo the slot count
				ram_rd_addr = key_hash[oaht_pkg::IDX_W-1:0];
				if (accept) begin
					case (func_in)
						oaht_pkg::FN_GET, oaht_pkg::FN_DEL: begin
							if (fill_count_q == '0) begin
								res_fire   = 1'b1;
								res_status = oaht_pkg::ST_ABSENT;
							end else begin
								probe_load = 1'b1;
								ram_re     = 1'b1;
							end
						end
						oaht_pkg::FN_SET: begin
							if (over_limit) begin
								res_fire   = 1'b1;
								res_status = oaht_pkg::ST_FULL;
							end else begin
								probe_load = 1'b1;
								ram_re     = 1'b1;
							end
						end
						oaht_pkg::FN_CLEAR: begin
							res_fire  = 1'b1;
							clear_all = 1'b1;
						end
						default: res_fire = 1'b0;
					endcase
				end
			end
			oaht_pkg::FSM_PROBE: begin
				ram_re = !finish;
				if (finish) begin
					res_fire = 1'b1;
					case (func_q)
						oaht_pkg::FN_GET: begin
							if (key_match) begin
								res_value = ram_rd_data.value;
							end else begin
								res_status = oaht_pkg::ST_ABSENT;
							end
						end
						oaht_pkg::FN_DEL: begin
							// tombstone keeps the old key and value bits
							if (key_match) begin
								ram_we      = 1'b1;
								ram_wr_data = '{kind: oaht_pkg::KIND_TOMB,
									key: ram_rd_data.key, value: ram_rd_data.value};
							end else begin
								res_status = oaht_pkg::ST_ABSENT;
							end
						end
						oaht_pkg::FN_SET: begin
							if (sel_valid) begin
								ram_we   = 1'b1;
								res_new  = !key_match;
								fill_inc = sel_was_empty;
							end else begin
								res_status = oaht_pkg::ST_FULL;
							end
						end
						default: res_fire = 1'b1;
					endcase
				end
			end
			default: res_fire = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= oaht_pkg::FSM_IDLE;
			valid_q      <= '0;
			fill_count_q <= '0;
			fill_limit_q <= oaht_pkg::LIMIT_RESET;
			idx_q        <= '0;
			probe_cnt_q  <= '0;
			tomb_seen_q  <= 1'b0;
			tomb_idx_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_fire;
			if (cfg_valid && cfg_ready) begin
				fill_limit_q <= cfg_data;
			end
			if (clear_all) begin
				valid_q      <= '0;
				fill_count_q <= '0;
			end else begin
				if (ram_we) begin
					valid_q[ram_wr_addr] <= 1'b1;
				end
				if (fill_inc) begin
					fill_count_q <= fill_count_q + 1'b1;
				end
			end
			if (probe_load) begin
				idx_q       <= key_hash[oaht_pkg::IDX_W-1:0];
				probe_cnt_q <= '0;
				tomb_seen_q <= 1'b0;
			end else if (ram_re) begin
				// step to the next slot, wrapping at the end
				idx_q       <= idx_q + 1'b1;
				probe_cnt_q <= probe_cnt_q + 1'b1;
				if (is_tomb && !tomb_seen_q) begin
					tomb_seen_q <= 1'b1;
					tomb_idx_q  <= idx_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (probe_load) begin
			func_q  <= func_in;
			key_q   <= key_id;
			value_q <= value_in;
		end
		if (res_fire) begin
			status_q    <= res_status;
			new_key_q   <= res_new;
			value_out_q <= res_value;
		end
	end

`ifndef ASSERT_OFF
	// a result only shows once the table is ready for the next request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the slot ram is written only at the end of a probe
	a_write_in_probe: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == oaht_pkg::FSM_PROBE) && finish)
		else $error("slot write outside probe end");

	// clear answers in the cycle after it is taken and empties the fill count
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func_in == oaht_pkg::FN_CLEAR)
		|=> (done && status == oaht_pkg::ST_DONE && fill_count_q == '0))
		else $error("clear did not complete");

	// a new key is only reported with a successful set
	a_new_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && new_key) |-> (status == oaht_pkg::ST_DONE && value_out == '0))
		else $error("new key flag on failed request");

	// fill count never passes the slot count
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= oaht_pkg::FILL_W'(oaht_pkg::SLOTS))
		else $error("fill count beyond slot count");
`endif

endmodule
